// ===== hdl/igcd_pkg.sv =====
// ============================================================================
// igcd_pkg - shared types and constants of the central-difference gradient
// Field widths, register map, result and pipeline-stage records.
// ============================================================================
package igcd_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_LINE_DEF   = 1024;
    localparam int PIXEL_BITS_DEF = 8;

    // Fixed field widths
    localparam int LEN_REG_W = 11;
    localparam int COL_W     = 16;
    localparam int ROW_OUT_W = 10;
    localparam int GRAD_W    = 10;

    // Register reset values
    localparam logic [LEN_REG_W-1:0] LEN_RESET   = 11'd480;
    localparam logic [COL_W-1:0]     COUNT_RESET = 16'd640;

    // Configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    typedef enum logic {
        REG_LINE_LENGTH = 1'b0,
        REG_LINE_COUNT  = 1'b1
    } reg_idx_t;

    // Output queue: up to three results per pixel request
    localparam int OUTQ_DEPTH = 8;
    localparam int PUSH_MAX   = 3;
    localparam int PUSH_W     = 2;

    typedef struct packed {
        logic [COL_W-1:0]     out_column;
        logic [ROW_OUT_W-1:0] out_row;
        logic [GRAD_W-1:0]    grad_x;
        logic [GRAD_W-1:0]    grad_y;
        logic                 frame_last;
    } result_t;

    // Results of one pixel, in delivery order; entries below n are valid
    typedef struct packed {
        logic [PUSH_W-1:0]          n;
        result_t [PUSH_MAX-1:0]     item;
    } push_t;

    // Position flags of a pixel, handed from the sequencer to the datapath
    typedef struct packed {
        logic [COL_W-1:0]     col;
        logic [ROW_OUT_W-1:0] row;
        logic                 first_row;
        logic                 row_one;
        logic                 last_row;
        logic                 past_len;
        logic                 has_prev;
        logic                 left_edge;
        logic                 last_col;
    } stage_t;

endpackage

// ===== hdl/image_gradient_central_difference.sv =====
// ============================================================================
// image_gradient_central_difference - central-difference image gradient
// Column-major pixel stream in, x/y gradients with row and column tags out.
// ============================================================================
// Result path: the first result of a pixel reaches the m_ port through
//   the store read and stage registers, then the queue write.
// Throughput: one pixel per cycle while results flow; in the last column
//   most pixels bring two results and the final row three, so the single
//   result port holds the input back there. An eight-entry result queue absorbs bursts.
// Reset: counters, bank rotation and queue clear, registers return to 480
//   and 640; the line store is not cleared and needs no clearing pass.
module image_gradient_central_difference import igcd_pkg::*; #(
    parameter int MAX_LINE   = MAX_LINE_DEF,
    parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // pixel input
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [PIXEL_BITS-1:0]       s_pixel,
    // result output
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [COL_W-1:0]            m_out_column,
    output logic [ROW_OUT_W-1:0]        m_out_row,
    output logic signed [GRAD_W-1:0]    m_grad_x,
    output logic signed [GRAD_W-1:0]    m_grad_y,
    output logic                        m_frame_last,
    // configuration
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [APB_ADDR_W-1:0]       paddr,
    input  logic [APB_DATA_W-1:0]       pwdata,
    output logic [APB_DATA_W-1:0]       prdata,
    output logic                        pready
);

    localparam int AW = $clog2(3*MAX_LINE);

    logic [LEN_REG_W-1:0]  len_reg;
    logic [COL_W-1:0]      cnt_reg;
    logic                  cfg_wr;
    reg_idx_t              cfg_idx;

    logic                  accept;
    logic                  wr_en, rd_en;
    logic [AW-1:0]         wr_addr, rd_addr_a, rd_addr_b;
    logic [PIXEL_BITS-1:0] wr_data, rd_a, rd_b;
    logic                  stg_valid;
    stage_t                stg;
    logic [PIXEL_BITS-1:0] stg_pixel;
    push_t                 push;
    logic                  room;
    result_t               head;

    // Configuration registers
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = reg_idx_t'(paddr[2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg <= LEN_RESET;
            cnt_reg <= COUNT_RESET;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_LINE_LENGTH: len_reg <= pwdata[LEN_REG_W-1:0];
                REG_LINE_COUNT:  cnt_reg <= pwdata[COL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_LINE_LENGTH: prdata = APB_DATA_W'(len_reg);
            REG_LINE_COUNT:  prdata = APB_DATA_W'(cnt_reg);
            default:         prdata = '0;
        endcase
    end

    // Input request handshake
    assign s_ready = room;
    assign accept  = s_valid && s_ready;

    igcd_seq #(
        .MAX_LINE   (MAX_LINE),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .pixel       (s_pixel),
        .line_length (len_reg),
        .line_count  (cnt_reg),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data),
        .rd_en       (rd_en),
        .rd_addr_a   (rd_addr_a),
        .rd_addr_b   (rd_addr_b),
        .stg_valid   (stg_valid),
        .stg         (stg),
        .stg_pixel   (stg_pixel)
    );

    // Three-bank line store
    igcd_ram #(
        .WIDTH (PIXEL_BITS),
        .DEPTH (3*MAX_LINE)
    ) u_line_store (
        .aclk      (aclk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_en_a   (rd_en),
        .rd_addr_a (rd_addr_a),
        .rd_data_a (rd_a),
        .rd_en_b   (rd_en),
        .rd_addr_b (rd_addr_b),
        .rd_data_b (rd_b)
    );

    igcd_grad #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_grad (
        .aclk      (aclk),
        .stg_valid (stg_valid),
        .stg       (stg),
        .stg_pixel (stg_pixel),
        .rd_a      (rd_a),
        .rd_b      (rd_b),
        .push      (push)
    );

    igcd_outq u_outq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .room    (room),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .head    (head)
    );

    // Result fields
    assign m_out_column = head.out_column;
    assign m_out_row    = head.out_row;
    assign m_grad_x     = $signed(head.grad_x);
    assign m_grad_y     = $signed(head.grad_y);
    assign m_frame_last = head.frame_last;

endmodule

// ===== hdl/igcd_ram.sv =====
// ============================================================================
// igcd_ram - generic synchronous RAM
// One write port, two read ports, registered read data.
// ============================================================================
module igcd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 3072
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en_a,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
    output logic [WIDTH-1:0]         rd_data_a,
    input  logic                     rd_en_b,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_a_reg;
    logic [WIDTH-1:0] rd_b_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en_a) begin
            rd_a_reg <= mem_reg[rd_addr_a];
        end
        if (rd_en_b) begin
            rd_b_reg <= mem_reg[rd_addr_b];
        end
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;

endmodule

// ===== hdl/igcd_seq.sv =====
// ============================================================================
// igcd_seq - row/column sequencer and line store addressing
// Counts position, rotates the three column banks, issues the store write
// and the two reads of each pixel, and registers the pixel's position flags.
// ============================================================================
module igcd_seq import igcd_pkg::*; #(
    parameter int MAX_LINE   = MAX_LINE_DEF,
    parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          accept,
    input  logic [PIXEL_BITS-1:0]         pixel,
    input  logic [LEN_REG_W-1:0]          line_length,
    input  logic [COL_W-1:0]              line_count,
    output logic                          wr_en,
    output logic [$clog2(3*MAX_LINE)-1:0] wr_addr,
    output logic [PIXEL_BITS-1:0]         wr_data,
    output logic                          rd_en,
    output logic [$clog2(3*MAX_LINE)-1:0] rd_addr_a,
    output logic [$clog2(3*MAX_LINE)-1:0] rd_addr_b,
    output logic                          stg_valid,
    output stage_t                        stg,
    output logic [PIXEL_BITS-1:0]         stg_pixel
);

    localparam int ROW_W = $clog2(MAX_LINE);
    localparam int AW    = $clog2(3*MAX_LINE);
    localparam int LW    = (LEN_REG_W > $clog2(MAX_LINE+1)) ? LEN_REG_W : $clog2(MAX_LINE+1);
    localparam logic [1:0] BANK_LAST = 2'd2;

    logic [ROW_W-1:0]      row_reg, row_next;
    logic [COL_W-1:0]      col_reg, col_next;
    logic [1:0]            bank_reg, bank_next;
    logic [LW-1:0]         len_eff;
    logic [COL_W-1:0]      cnt_eff;
    logic                  last_row, past_len, last_col;
    logic                  stg_valid_reg;
    stage_t                stg_reg;
    logic [PIXEL_BITS-1:0] pix_reg;

    // Bank rotation: current, one column back, two columns back
    function automatic logic [1:0] rot_fwd(input logic [1:0] b);
        case (b)
            2'd0:    rot_fwd = 2'd1;
            2'd1:    rot_fwd = 2'd2;
            default: rot_fwd = 2'd0;
        endcase
    endfunction

    function automatic logic [1:0] rot_back(input logic [1:0] b);
        case (b)
            2'd0:    rot_back = 2'd2;
            2'd1:    rot_back = 2'd0;
            default: rot_back = 2'd1;
        endcase
    endfunction

    function automatic logic [AW-1:0] line_addr(input logic [1:0] b,
                                                input logic [ROW_W-1:0] r);
        case (b)
            2'd0:    line_addr = AW'(r);
            2'd1:    line_addr = AW'(MAX_LINE) + AW'(r);
            default: line_addr = AW'(2*MAX_LINE) + AW'(r);
        endcase
    endfunction

    // Effective geometry: length clamped to 2..MAX_LINE, count to at least 2
    always_comb begin
        if (LW'(line_length) < LW'(2)) begin
            len_eff = LW'(2);
        end else if (LW'(line_length) > LW'(MAX_LINE)) begin
            len_eff = LW'(MAX_LINE);
        end else begin
            len_eff = LW'(line_length);
        end
        cnt_eff  = (line_count < COL_W'(2)) ? COL_W'(2) : line_count;
        last_row = LW'(row_reg) >= len_eff - LW'(1);
        past_len = LW'(row_reg) >= len_eff;
        last_col = col_reg >= cnt_eff - COL_W'(1);
    end

    // Line store access: write current bank; read ahead in the previous
    // column, or on the final row fetch row 0 of the column that becomes
    // the previous one; read b is the row two columns back. No read hits
    // the entry being written; only the final-row read shares its bank.
    assign wr_en     = accept;
    assign wr_data   = pixel;
    assign wr_addr   = line_addr(bank_reg, row_reg);
    assign rd_en     = accept;
    assign rd_addr_a = last_row ? line_addr(bank_reg, '0)
                                : line_addr(rot_back(bank_reg), row_reg + ROW_W'(1));
    assign rd_addr_b = line_addr(rot_fwd(bank_reg), row_reg);

    // Position counters
    always_comb begin
        row_next  = row_reg;
        col_next  = col_reg;
        bank_next = bank_reg;
        if (accept) begin
            if (last_row) begin
                row_next = '0;
                if (last_col) begin
                    col_next  = '0;
                    bank_next = '0;
                end else begin
                    col_next  = col_reg + COL_W'(1);
                    bank_next = rot_fwd(bank_reg);
                end
            end else begin
                row_next = row_reg + ROW_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg       <= '0;
            col_reg       <= '0;
            bank_reg      <= '0;
            stg_valid_reg <= 1'b0;
        end else begin
            row_reg       <= row_next;
            col_reg       <= col_next;
            bank_reg      <= bank_next;
            stg_valid_reg <= accept;
        end
    end

    // Position flags travel with the pixel to the datapath stage
    always_ff @(posedge aclk) begin
        if (accept) begin
            stg_reg.col       <= col_reg;
            stg_reg.row       <= ROW_OUT_W'(row_reg);
            stg_reg.first_row <= (row_reg == '0);
            stg_reg.row_one   <= (row_reg == ROW_W'(1));
            stg_reg.last_row  <= last_row;
            stg_reg.past_len  <= past_len;
            stg_reg.has_prev  <= (col_reg != '0);
            stg_reg.left_edge <= (col_reg == COL_W'(1));
            stg_reg.last_col  <= last_col;
            pix_reg           <= pixel;
        end
    end

    assign stg_valid = stg_valid_reg;
    assign stg       = stg_reg;
    assign stg_pixel = pix_reg;

    a_no_rw_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> (rd_addr_a != wr_addr) && (rd_addr_b != wr_addr))
        else $error("line store read collides with write");

    a_bank_range: assert property (@(posedge aclk) disable iff (!aresetn)
        bank_reg <= BANK_LAST)
        else $error("bank rotation out of range");

endmodule

// ===== hdl/igcd_grad.sv =====
// ============================================================================
// igcd_grad - gradient datapath
// Combines the line store read data with short registered windows of the
// previous and current column and forms up to three results per pixel.
// ============================================================================
module igcd_grad import igcd_pkg::*; #(
    parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  stg_valid,
    input  stage_t                stg,
    input  logic [PIXEL_BITS-1:0] stg_pixel,
    input  logic [PIXEL_BITS-1:0] rd_a,
    input  logic [PIXEL_BITS-1:0] rd_b,
    output push_t                 push
);

    localparam int DW = (PIXEL_BITS + 2 > GRAD_W) ? PIXEL_BITS + 2 : GRAD_W;

    // prev column window: p0 = row r-1, p1 = row r; pre0 = row 0 of the
    // column that becomes previous next. x1/x2 = current column rows r-1, r-2.
    logic [PIXEL_BITS-1:0] p0_reg, p1_reg, pre0_reg, x1_reg, x2_reg;
    logic [PIXEL_BITS-1:0] prev_r;
    result_t               res_a, res_b, res_c;
    logic [PUSH_W-1:0]     n;

    // Half-unit difference, doubled for one-sided borders, kept to GRAD_W bits
    function automatic logic [GRAD_W-1:0] diff(input logic [PIXEL_BITS-1:0] a,
                                               input logic [PIXEL_BITS-1:0] b,
                                               input logic dbl);
        logic [DW-1:0] d;
        d = DW'(a) - DW'(b);
        if (dbl) begin
            d = d << 1;
        end
        return d[GRAD_W-1:0];
    endfunction

    assign prev_r = stg.first_row ? pre0_reg : p1_reg;

    // Previous column at this row
    always_comb begin
        res_a.out_column = stg.col - COL_W'(1);
        res_a.out_row    = stg.row;
        res_a.grad_x     = stg.left_edge ? diff(stg_pixel, prev_r, 1'b1)
                                         : diff(stg_pixel, rd_b, 1'b0);
        if (stg.first_row) begin
            res_a.grad_y = diff(rd_a, prev_r, 1'b1);
        end else if (stg.last_row) begin
            res_a.grad_y = diff(prev_r, p0_reg, 1'b1);
        end else begin
            res_a.grad_y = diff(rd_a, p0_reg, 1'b0);
        end
        res_a.frame_last = 1'b0;
    end

    // Last column, one row up
    always_comb begin
        res_b.out_column = stg.col;
        res_b.out_row    = stg.row - ROW_OUT_W'(1);
        res_b.grad_x     = diff(x1_reg, p0_reg, 1'b1);
        if (stg.row_one) begin
            res_b.grad_y = diff(stg_pixel, x1_reg, 1'b1);
        end else if (stg.past_len) begin
            res_b.grad_y = diff(x1_reg, x2_reg, 1'b1);
        end else begin
            res_b.grad_y = diff(stg_pixel, x2_reg, 1'b0);
        end
        res_b.frame_last = 1'b0;
    end

    // Last column, final row: closes the frame
    always_comb begin
        res_c.out_column = stg.col;
        res_c.out_row    = stg.row;
        res_c.grad_x     = diff(stg_pixel, prev_r, 1'b1);
        res_c.grad_y     = diff(stg_pixel, x1_reg, 1'b1);
        res_c.frame_last = 1'b1;
    end

    // Result count: none, A, A+B or A+B+C
    always_comb begin
        if (!stg_valid || !stg.has_prev) begin
            n = PUSH_W'(0);
        end else if (!stg.last_col || stg.first_row) begin
            n = PUSH_W'(1);
        end else if (!stg.last_row) begin
            n = PUSH_W'(2);
        end else begin
            n = PUSH_W'(3);
        end
    end

    assign push.n       = n;
    assign push.item[0] = res_a;
    assign push.item[1] = res_b;
    assign push.item[2] = res_c;

    // Slide the windows
    always_ff @(posedge aclk) begin
        if (stg_valid) begin
            p0_reg <= prev_r;
            p1_reg <= rd_a;
            x2_reg <= x1_reg;
            x1_reg <= stg_pixel;
            if (stg.last_row) begin
                pre0_reg <= rd_a;
            end
        end
    end

endmodule

// ===== hdl/igcd_outq.sv =====
// ============================================================================
// igcd_outq - result queue
// Takes up to three results a cycle, delivers one per output request, and
// reports whether another pixel can be taken without overflow.
// ============================================================================
module igcd_outq import igcd_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  push_t   push,
    output logic    room,
    output logic    m_valid,
    input  logic    m_ready,
    output result_t head
);

    localparam int QA_W = $clog2(OUTQ_DEPTH);
    localparam int QC_W = $clog2(OUTQ_DEPTH + 1);
    localparam int SW   = QC_W + 1;

    result_t         q_reg [OUTQ_DEPTH];
    logic [QA_W-1:0] wp_reg, wp_next, rp_reg, rp_next;
    logic [QC_W-1:0] cnt_reg, cnt_next;
    logic            pop;

    assign pop     = m_valid && m_ready;
    assign m_valid = (cnt_reg != '0);
    assign head    = q_reg[rp_reg];

    // Space for the results now being written plus a full pixel more
    assign room = (SW'(cnt_reg) + SW'(push.n)) <= SW'(OUTQ_DEPTH - PUSH_MAX);

    always_comb begin
        wp_next  = wp_reg + QA_W'(push.n);
        rp_next  = pop ? rp_reg + QA_W'(1) : rp_reg;
        cnt_next = cnt_reg + QC_W'(push.n) - QC_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    // Entry storage
    always_ff @(posedge aclk) begin
        for (int i = 0; i < PUSH_MAX; i++) begin
            if (PUSH_W'(i) < push.n) begin
                q_reg[wp_reg + QA_W'(i)] <= push.item[i];
            end
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        (SW'(cnt_reg) + SW'(push.n)) <= (SW'(OUTQ_DEPTH) + SW'(pop)))
        else $error("result queue overflow");

    a_ptr_count: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg[QA_W-1:0] == QA_W'(wp_reg - rp_reg))
        else $error("result queue pointers disagree with count");

endmodule
